@@ src/wpu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and register map for the world-to-screen projection unit.
// No dependencies; every other file except wpu_div refers to this package by scoped names.
package wpu_pkg;

	// One projection row: three weights and a translation, signed fixed point.
	typedef struct packed {
		logic signed [31:0] w_x;
		logic signed [31:0] w_y;
		logic signed [31:0] w_z;
		logic signed [31:0] trans;
	} coef_row_t;

	// Decoded configuration as seen by the datapath.
	typedef struct packed {
		coef_row_t          row_x;
		coef_row_t          row_y;
		coef_row_t          row_d;
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [15:0]        win_w;
		logic [15:0]        win_h;
	} wpu_cfg_t;

	localparam int ADDR_W   = 6;
	localparam int ADDR_LSB = 3;
	localparam int DATA_W   = 64;

	localparam logic [2:0] REG_X_FIRST  = 3'd0;
	localparam logic [2:0] REG_X_SECOND = 3'd1;
	localparam logic [2:0] REG_Y_FIRST  = 3'd2;
	localparam logic [2:0] REG_Y_SECOND = 3'd3;
	localparam logic [2:0] REG_D_FIRST  = 3'd4;
	localparam logic [2:0] REG_D_SECOND = 3'd5;
	localparam logic [2:0] REG_ORIGIN   = 3'd6;
	localparam logic [2:0] REG_EXTENT   = 3'd7;

endpackage

@@ src/world_to_screen_projection_unit.sv @@
`timescale 1ns / 1ps
// Top level of the world-to-screen projection unit: rows, scaling, two dividers, output.
// Depends on wpu_pkg, wpu_cfg, wpu_row and wpu_div.
//
//  channel   handshake                  payload
//  point     point_valid / point_stall  world_x, world_y, world_z
//  result    result_valid / result_stall visible, screen_x, screen_y, depth
//  config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One point enters per cycle while point_stall is low; the divider yields one quotient
// bit per stage over 47 + FRAC_BITS stages.
// Reset clears all valid bits and loads the register reset values.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
module world_to_screen_projection_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wpu_pkg::ADDR_W-1:0]    paddr,
	input  logic [wpu_pkg::DATA_W-1:0]    pwdata,
	output logic [wpu_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          point_valid,
	output logic                          point_stall,
	input  logic signed [31:0]            world_x,
	input  logic signed [31:0]            world_y,
	input  logic signed [31:0]            world_z,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          visible,
	output logic signed [31:0]            screen_x,
	output logic signed [31:0]            screen_y,
	output logic signed [31:0]            depth
);

	localparam int MAG_W  = 47;
	localparam int NUM_W  = MAG_W + FRAC_BITS;
	localparam int DEN_W  = 33;
	localparam int SW     = 41 + FRAC_BITS;
	localparam int SIDE_W = 2 + 2 * SW + 32;
	localparam int CAP_W  = 39 + FRAC_BITS;
	localparam logic [NUM_W-1:0] CAP = NUM_W'(1) << (38 + FRAC_BITS);
	localparam logic signed [31:0] NEAR = 32'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

	wpu_pkg::wpu_cfg_t cfg;
	logic en;
	logic vld_s1, vld_s2, vld_s3;
	logic signed [31:0] rx, ry, dz;

	logic               vis_s3;
	logic signed [48:0] nx_s3, ny_s3;
	logic signed [SW-1:0] cx_s3, cy_s3;
	logic signed [31:0] dz_s3;

	logic [48:0]        absx, absy;
	logic [NUM_W-1:0]   numx, numy;
	logic [DEN_W-1:0]   den;
	logic [SIDE_W-1:0]  side_x, side_x_out;
	logic [0:0]         side_y_out;
	logic               div_vld_x, div_vld_y;
	logic [NUM_W-1:0]   qx, qy;

	logic               neg_x, neg_y, vis_d;
	logic signed [SW-1:0] cx_d, cy_d, offx, offy, sx, sy;
	logic signed [31:0] dz_d;
	logic [CAP_W-1:0]   magx, magy;

	logic vld_q, vis_q;
	logic signed [31:0] sx_q, sy_q, dz_q;

	assign pready      = 1'b1;
	assign en          = !vld_q || !result_stall;
	assign point_stall = !en;

	wpu_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
	);

	wpu_row #(.FRAC_BITS(FRAC_BITS)) u_row_x (.clk, .en, .coef(cfg.row_x),
		.px(world_x), .py(world_y), .pz(world_z), .sum(rx));
	wpu_row #(.FRAC_BITS(FRAC_BITS)) u_row_y (.clk, .en, .coef(cfg.row_y),
		.px(world_x), .py(world_y), .pz(world_z), .sum(ry));
	wpu_row #(.FRAC_BITS(FRAC_BITS)) u_row_d (.clk, .en, .coef(cfg.row_d),
		.px(world_x), .py(world_y), .pz(world_z), .sum(dz));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= point_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// scale rows by window size, place the window centre, test the near limit
	always_ff @(posedge clk) begin
		if (en) begin
			vis_s3 <= dz >= NEAR;
			nx_s3  <= rx * $signed({1'b0, cfg.win_w});
			ny_s3  <= ry * $signed({1'b0, cfg.win_h});
			cx_s3  <= (SW'(cfg.left) <<< FRAC_BITS)
				+ (SW'($signed({1'b0, cfg.win_w})) <<< (FRAC_BITS - 1));
			cy_s3  <= (SW'(cfg.top) <<< FRAC_BITS)
				+ (SW'($signed({1'b0, cfg.win_h})) <<< (FRAC_BITS - 1));
			dz_s3  <= dz;
		end
	end

	assign absx   = nx_s3[48] ? 49'(-nx_s3) : nx_s3;
	assign absy   = ny_s3[48] ? 49'(-ny_s3) : ny_s3;
	assign numx   = {absx[MAG_W-1:0], {FRAC_BITS{1'b0}}};
	assign numy   = {absy[MAG_W-1:0], {FRAC_BITS{1'b0}}};
	assign den    = {dz_s3, 1'b0};
	assign side_x = {nx_s3[48], vis_s3, cx_s3, cy_s3, dz_s3};

	wpu_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(SIDE_W)) u_div_x (
		.clk, .arst_n, .en, .in_valid(vld_s3), .num(numx), .den, .side(side_x),
		.out_valid(div_vld_x), .quo(qx), .side_out(side_x_out)
	);

	wpu_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(1)) u_div_y (
		.clk, .arst_n, .en, .in_valid(vld_s3), .num(numy), .den, .side(ny_s3[48]),
		.out_valid(div_vld_y), .quo(qy), .side_out(side_y_out)
	);

	assign {neg_x, vis_d, cx_d, cy_d, dz_d} = side_x_out;
	assign neg_y = side_y_out[0];

	// clamp huge offsets, restore sign, add centre
	assign magx = (qx >= CAP) ? CAP[CAP_W-1:0] : qx[CAP_W-1:0];
	assign magy = (qy >= CAP) ? CAP[CAP_W-1:0] : qy[CAP_W-1:0];
	assign offx = neg_x ? -SW'(magx) : SW'(magx);
	assign offy = neg_y ? -SW'(magy) : SW'(magy);
	assign sx   = cx_d + offx;
	assign sy   = cy_d - offy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (en)
			vld_q <= div_vld_x;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_q <= vis_d;
			if (!vis_d) begin
				sx_q <= '0;
				sy_q <= '0;
				dz_q <= '0;
			end else begin
				if (sx > SW'(32'sh7fffffff))
					sx_q <= 32'sh7fffffff;
				else if (sx < SW'(32'sh80000000))
					sx_q <= 32'sh80000000;
				else
					sx_q <= sx[31:0];
				if (sy > SW'(32'sh7fffffff))
					sy_q <= 32'sh7fffffff;
				else if (sy < SW'(32'sh80000000))
					sy_q <= 32'sh80000000;
				else
					sy_q <= sy[31:0];
				dz_q <= dz_d;
			end
		end
	end

	assign result_valid = vld_q;
	assign visible      = vis_q;
	assign screen_x     = sx_q;
	assign screen_y     = sy_q;
	assign depth        = dz_q;

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !visible |-> screen_x == 0 && screen_y == 0 && depth == 0)
		else $error("hidden point with non-zero result");

	a_visible_near: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && visible |-> depth >= NEAR)
		else $error("visible point nearer than the near limit");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld_x == div_vld_y)
		else $error("divider lanes out of step");

endmodule

@@ src/wpu_cfg.sv @@
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on wpu_pkg for the register map and the decoded configuration type.
module wpu_cfg #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wpu_pkg::ADDR_W-1:0]          paddr,
	input  logic [wpu_pkg::DATA_W-1:0]          pwdata,
	output logic [wpu_pkg::DATA_W-1:0]          prdata,
	output wpu_pkg::wpu_cfg_t                   cfg
);

	localparam logic [63:0] D_SECOND_RST = 64'(64'd1 << FRAC_BITS);

	logic [63:0] x_first_q, x_second_q, y_first_q, y_second_q;
	logic [63:0] d_first_q, d_second_q;
	logic [31:0] origin_q, extent_q;
	logic [2:0]  idx;
	logic        wr;

	assign idx = paddr[wpu_pkg::ADDR_W-1:wpu_pkg::ADDR_LSB];
	assign wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_first_q  <= '0;
			x_second_q <= '0;
			y_first_q  <= '0;
			y_second_q <= '0;
			d_first_q  <= '0;
			d_second_q <= D_SECOND_RST;
			origin_q   <= '0;
			extent_q   <= '0;
		end else if (wr) begin
			case (idx)
				wpu_pkg::REG_X_FIRST:  x_first_q  <= pwdata;
				wpu_pkg::REG_X_SECOND: x_second_q <= pwdata;
				wpu_pkg::REG_Y_FIRST:  y_first_q  <= pwdata;
				wpu_pkg::REG_Y_SECOND: y_second_q <= pwdata;
				wpu_pkg::REG_D_FIRST:  d_first_q  <= pwdata;
				wpu_pkg::REG_D_SECOND: d_second_q <= pwdata;
				wpu_pkg::REG_ORIGIN:   origin_q   <= pwdata[31:0];
				wpu_pkg::REG_EXTENT:   extent_q   <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			wpu_pkg::REG_X_FIRST:  prdata = x_first_q;
			wpu_pkg::REG_X_SECOND: prdata = x_second_q;
			wpu_pkg::REG_Y_FIRST:  prdata = y_first_q;
			wpu_pkg::REG_Y_SECOND: prdata = y_second_q;
			wpu_pkg::REG_D_FIRST:  prdata = d_first_q;
			wpu_pkg::REG_D_SECOND: prdata = d_second_q;
			wpu_pkg::REG_ORIGIN:   prdata = 64'(origin_q);
			wpu_pkg::REG_EXTENT:   prdata = 64'(extent_q);
			default:               prdata = '0;
		endcase
	end

	always_comb begin
		cfg.row_x = '{w_x: x_first_q[31:0], w_y: x_first_q[63:32],
			w_z: x_second_q[31:0], trans: x_second_q[63:32]};
		cfg.row_y = '{w_x: y_first_q[31:0], w_y: y_first_q[63:32],
			w_z: y_second_q[31:0], trans: y_second_q[63:32]};
		cfg.row_d = '{w_x: d_first_q[31:0], w_y: d_first_q[63:32],
			w_z: d_second_q[31:0], trans: d_second_q[63:32]};
		cfg.left  = origin_q[15:0];
		cfg.top   = origin_q[31:16];
		cfg.win_w = extent_q[15:0];
		cfg.win_h = extent_q[31:16];
	end

endmodule

@@ src/wpu_row.sv @@
`timescale 1ns / 1ps
// One projection row over two stages: three products, then floor shift, sum, saturate.
// Depends on wpu_pkg for the row coefficient type.
module wpu_row #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      en,
	input  wpu_pkg::coef_row_t        coef,
	input  logic signed [31:0]        px,
	input  logic signed [31:0]        py,
	input  logic signed [31:0]        pz,
	output logic signed [31:0]        sum
);

	logic signed [63:0] prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [31:0] trans_s1;
	logic signed [63:0] sh_x, sh_y, sh_z;
	logic signed [65:0] acc;
	logic signed [31:0] sum_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s1 <= coef.w_x * px;
			prod_y_s1 <= coef.w_y * py;
			prod_z_s1 <= coef.w_z * pz;
			trans_s1  <= coef.trans;
		end
	end

	// arithmetic shift rounds toward minus infinity
	assign sh_x = prod_x_s1 >>> FRAC_BITS;
	assign sh_y = prod_y_s1 >>> FRAC_BITS;
	assign sh_z = prod_z_s1 >>> FRAC_BITS;
	assign acc  = 66'(sh_x) + 66'(sh_y) + 66'(sh_z) + 66'(trans_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			if (acc > 66'sd2147483647)
				sum_s2 <= 32'sh7fffffff;
			else if (acc < -66'sd2147483648)
				sum_s2 <= 32'sh80000000;
			else
				sum_s2 <= acc[31:0];
		end
	end

	assign sum = sum_s2;

endmodule

@@ src/wpu_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with sideband carried along.
// Standalone; uses no package items.
module wpu_div #(
	parameter int NUM_W  = 63,
	parameter int DEN_W  = 33,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);

	logic [DEN_W-1:0]  rem_s  [NUM_W];
	logic [NUM_W-1:0]  num_s  [NUM_W];
	logic [NUM_W-1:0]  quo_s  [NUM_W];
	logic [DEN_W-1:0]  den_s  [NUM_W];
	logic [SIDE_W-1:0] side_s [NUM_W];
	logic [NUM_W-1:0]  vld_s;

	logic [DEN_W-1:0]  rem_n  [NUM_W];
	logic [NUM_W-1:0]  num_n  [NUM_W];
	logic [NUM_W-1:0]  quo_n  [NUM_W];
	logic [DEN_W-1:0]  den_n  [NUM_W];

	always_comb begin
		logic [DEN_W-1:0] p_rem, p_den;
		logic [NUM_W-1:0] p_num, p_quo;
		logic [DEN_W:0]   trial;
		logic             ge;
		for (int k = 0; k < NUM_W; k++) begin
			if (k == 0) begin
				p_rem = '0;
				p_num = num;
				p_quo = '0;
				p_den = den;
			end else begin
				p_rem = rem_s[k-1];
				p_num = num_s[k-1];
				p_quo = quo_s[k-1];
				p_den = den_s[k-1];
			end
			trial = {p_rem, p_num[NUM_W-1]};
			ge    = trial >= {1'b0, p_den};
			if (ge)
				rem_n[k] = DEN_W'(trial - {1'b0, p_den});
			else
				rem_n[k] = trial[DEN_W-1:0];
			quo_n[k] = {p_quo[NUM_W-2:0], ge};
			num_n[k] = {p_num[NUM_W-2:0], 1'b0};
			den_n[k] = p_den;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[NUM_W-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side;
			for (int k = 0; k < NUM_W; k++) begin
				rem_s[k] <= rem_n[k];
				num_s[k] <= num_n[k];
				quo_s[k] <= quo_n[k];
				den_s[k] <= den_n[k];
			end
			for (int k = 1; k < NUM_W; k++)
				side_s[k] <= side_s[k-1];
		end
	end

	assign out_valid = vld_s[NUM_W-1];
	assign quo       = quo_s[NUM_W-1];
	assign side_out  = side_s[NUM_W-1];

endmodule

@@ verif/world_to_screen_projection_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the world-to-screen projection unit: APB register setup,
// directed and random points, bit-exact projection predictor. Depends on wpu_pkg.
module world_to_screen_projection_unit_test;

	localparam int FB = 16;
	localparam longint NEAR = ((64'sd1 <<< FB) + 50) / 100;
	localparam longint CAP = 64'sd1 <<< 38;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [wpu_pkg::ADDR_W-1:0] paddr = '0;
	logic [wpu_pkg::DATA_W-1:0] pwdata = '0;
	logic [wpu_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic point_valid = 0;
	logic point_stall;
	logic signed [31:0] world_x = 0, world_y = 0, world_z = 0;
	logic result_valid;
	logic result_stall = 0;
	logic visible;
	logic signed [31:0] screen_x, screen_y, depth;

	world_to_screen_projection_unit #(.FRAC_BITS(FB)) uut (.*);

	typedef struct packed {
		logic               vis;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] dz;
	} projection_t;

	logic [63:0] regs [8];
	projection_t pending_projections [$];
	int mismatches = 0;
	int points_sent = 0;
	int results_seen = 0;
	int visible_seen = 0;
	bit stall_mode = 0;

	initial forever #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("world_to_screen_projection_unit test failed");
		$finish;
	end

	function automatic longint sx32(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint floor_shr(longint v);
		return v >>> FB;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint row_dot(logic [63:0] f, logic [63:0] s,
			longint px, longint py, longint pz);
		return clamp32(floor_shr(sx32(f[31:0]) * px) + floor_shr(sx32(f[63:32]) * py)
			+ floor_shr(sx32(s[31:0]) * pz) + sx32(s[63:32]));
	endfunction

	function automatic longint perspective_offset(longint r, longint sz, longint dz);
		longint n;
		bit neg;
		logic [63:0] m, d, q, rm, mag;
		n = r * sz;
		neg = n < 0;
		m = neg ? -n : n;
		d = 2 * dz;
		q = m / d;
		rm = m % d;
		if (q >= CAP) mag = CAP <<< FB;
		else mag = (q << FB) + ((rm << FB) / d);
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic projection_t project_point(logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		projection_t p;
		longint px, py, pz, dz, rx, ry, lf, tp, w, h;
		px = sx32(x); py = sx32(y); pz = sx32(z);
		dz = row_dot(regs[wpu_pkg::REG_D_FIRST], regs[wpu_pkg::REG_D_SECOND], px, py, pz);
		p = '0;
		if (dz < NEAR) return p;
		rx = row_dot(regs[wpu_pkg::REG_X_FIRST], regs[wpu_pkg::REG_X_SECOND], px, py, pz);
		ry = row_dot(regs[wpu_pkg::REG_Y_FIRST], regs[wpu_pkg::REG_Y_SECOND], px, py, pz);
		lf = longint'(signed'(regs[wpu_pkg::REG_ORIGIN][15:0]));
		tp = longint'(signed'(regs[wpu_pkg::REG_ORIGIN][31:16]));
		w = longint'(regs[wpu_pkg::REG_EXTENT][15:0]);
		h = longint'(regs[wpu_pkg::REG_EXTENT][31:16]);
		p.vis = 1;
		p.sx = 32'(clamp32((lf <<< FB) + w * (64'sd1 <<< (FB - 1))
			+ perspective_offset(rx, w, dz)));
		p.sy = 32'(clamp32((tp <<< FB) + h * (64'sd1 <<< (FB - 1))
			- perspective_offset(ry, h, dz)));
		p.dz = 32'(dz);
		return p;
	endfunction

	// receiver: stall on its own pattern, check at the rising edge
	always @(posedge clk) begin
		projection_t e;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (visible) visible_seen++;
			if (pending_projections.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
			end else begin
				e = pending_projections.pop_front();
				if (e.vis !== visible || e.sx !== screen_x || e.sy !== screen_y
						|| e.dz !== depth) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp v=%0b x=%h y=%h d=%h got v=%0b x=%h y=%h d=%h",
							e.vis, e.sx, e.sy, e.dz, visible, screen_x, screen_y, depth);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_mode) result_stall <= ($urandom_range(0, 3) == 0);
		else result_stall <= 0;
	end

	task automatic write_reg(int idx, logic [63:0] v);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= wpu_pkg::ADDR_W'(idx << wpu_pkg::ADDR_LSB);
		pwdata <= v;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		regs[idx] = (idx >= 6) ? {32'd0, v[31:0]} : v;
	endtask

	// wait for the pipeline to empty before touching registers
	task automatic drain();
		while (pending_projections.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		@(negedge clk);
		point_valid <= 1;
		world_x <= x; world_y <= y; world_z <= z;
		do @(posedge clk); while (point_stall);
		pending_projections = {pending_projections, project_point(x, y, z)};
		points_sent++;
	endtask

	task automatic idle_gap();
		int g;
		g = $urandom_range(0, 4) == 0 ? $urandom_range(1, 6) : 0;
		if (g != 0) begin
			@(negedge clk);
			point_valid <= 0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic stop_sending();
		@(negedge clk);
		point_valid <= 0;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 40 << FB)) - (20 << FB));
		endcase
	endfunction

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 0;
			default: return 32'($signed($urandom_range(0, 4 << FB)) - (2 << FB));
		endcase
	endfunction

	task automatic load_camera(bit wild);
		for (int i = 0; i < 6; i++) begin
			if (wild) write_reg(i, {$urandom(), $urandom()});
			else write_reg(i, {rand_weight(), rand_weight()});
		end
		// keep depth mostly positive: z weight from zero to two, translation from one to thirty
		if (!wild && $urandom_range(0, 3) != 0)
			write_reg(wpu_pkg::REG_D_SECOND,
				{32'($urandom_range(1 << FB, 30 << FB)), 32'($urandom_range(0, 2 << FB))});
		write_reg(wpu_pkg::REG_ORIGIN, 64'($urandom()));
		write_reg(wpu_pkg::REG_EXTENT, wild ? 64'($urandom())
			: 64'({16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000))}));
	endtask

	task automatic test_reset_defaults();
		// identity depth, zero window: depth equals z for visible points
		send_point(0, 0, 1 << FB);
		send_point(0, 0, 0);
		send_point(0, 0, 32'(NEAR));
		send_point(0, 0, 32'(NEAR - 1));
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_point(0, 0, 32'h8000_0000);
		stop_sending();
		drain();
	endtask

	task automatic test_directed_extremes();
		write_reg(wpu_pkg::REG_X_FIRST, {32'h0, 32'h0001_0000});
		write_reg(wpu_pkg::REG_X_SECOND, 64'h0);
		write_reg(wpu_pkg::REG_Y_FIRST, {32'h0001_0000, 32'h0});
		write_reg(wpu_pkg::REG_Y_SECOND, 64'h0);
		write_reg(wpu_pkg::REG_D_FIRST, 64'h0);
		write_reg(wpu_pkg::REG_D_SECOND, 64'h0000_0000_0001_0000);
		write_reg(wpu_pkg::REG_ORIGIN, 64'({16'sd100, -16'sd50}));
		write_reg(wpu_pkg::REG_EXTENT, 64'({16'd480, 16'd640}));
		send_point(1 << FB, 1 << FB, 2 << FB);
		send_point(-(3 << FB), 5 << FB, 1 << FB);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'(NEAR));
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'(NEAR));
		send_point(0, 0, 32'(NEAR - 1));
		stop_sending();
		drain();
		// full-scale window, extreme origin: saturation of both screen axes
		write_reg(wpu_pkg::REG_ORIGIN, 64'h7FFF_7FFF);
		write_reg(wpu_pkg::REG_EXTENT, 64'hFFFF_FFFF);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'(NEAR));
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'(NEAR));
		stop_sending();
		drain();
		write_reg(wpu_pkg::REG_ORIGIN, 64'h8000_8000);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'(NEAR));
		send_point(0, 0, 32'h7FFF_FFFF);
		stop_sending();
		drain();
		// empty window, all-ones coefficients and largest positive coefficients
		write_reg(wpu_pkg::REG_EXTENT, 64'h0);
		send_point(3 << FB, 4 << FB, 1 << FB);
		stop_sending();
		drain();
		for (int i = 0; i < 6; i++) write_reg(i, 64'hFFFF_FFFF_FFFF_FFFF);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		stop_sending();
		drain();
		for (int i = 0; i < 6; i++) write_reg(i, 64'h7FFF_FFFF_7FFF_FFFF);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		stop_sending();
		drain();
	endtask

	task automatic test_random_points(int n, bit wild);
		load_camera(wild);
		for (int i = 0; i < n; i++) begin
			send_point(rand_coord(), rand_coord(), rand_coord());
			idle_gap();
		end
		stop_sending();
		drain();
	endtask

	task automatic test_pause_until_empty();
		load_camera(0);
		repeat (20) send_point(rand_coord(), rand_coord(), rand_coord());
		stop_sending();
		// hold off until every result is out, then resume
		while (pending_projections.size() != 0) @(posedge clk);
		repeat (20) send_point(rand_coord(), rand_coord(), rand_coord());
		stop_sending();
		drain();
	endtask

	initial begin
		for (int i = 0; i < 8; i++) regs[i] = 0;
		regs[wpu_pkg::REG_D_SECOND] = 64'd65536;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		test_reset_defaults();
		test_directed_extremes();
		stall_mode = 1;
		for (int r = 0; r < 8; r++) begin
			stall_mode = (r % 3 != 0);
			test_random_points(100, r % 4 == 3);
		end
		test_pause_until_empty();
		stall_mode = 0;
		drain();
		$display("points sent %0d, results checked %0d (%0d visible), %0d mismatches",
			points_sent, results_seen, visible_seen, mismatches);
		$display("covered reset defaults, near-limit edges, saturation, empty window, random cameras");
		if (mismatches == 0 && pending_projections.size() == 0)
			$display("world_to_screen_projection_unit test passed");
		else
			$display("world_to_screen_projection_unit test failed");
		$finish;
	end

endmodule

@@ files.f @@
src/wpu_pkg.sv
src/wpu_cfg.sv
src/wpu_row.sv
src/wpu_div.sv
src/world_to_screen_projection_unit.sv
verif/world_to_screen_projection_unit_test.sv
